// ===== rtl/ssbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbl_pkg: shared definitions for the spherical shell bin locator
// Store sizes, opcodes, register indexes and the sideband record that
// travels with each item through the pipeline.
// ----------------------------------------------------------------------------
package ssbl_pkg;

    localparam int COARSE_SLOTS = 1024;
    localparam int MAX_BINS     = 256;
    localparam int CM_AW        = $clog2(COARSE_SLOTS);
    localparam int BIN_AW       = $clog2(MAX_BINS);

    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = 32;

    localparam logic [1:0] OP_LOCATE  = 2'd0;
    localparam logic [1:0] OP_WR_MAP  = 2'd1;
    localparam logic [1:0] OP_WR_BIN  = 2'd2;

    localparam logic [2:0] REG_CENTRE_X      = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y      = 3'd1;
    localparam logic [2:0] REG_CENTRE_Z      = 3'd2;
    localparam logic [2:0] REG_SPHERE_RADIUS = 3'd3;
    localparam logic [2:0] REG_COARSE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_COARSE_COUNT  = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [7:0]  map_bin;
        logic [31:0] bc;
        logic [31:0] bw;
    } side_t;

endpackage

// ===== rtl/spherical_shell_bin_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_shell_bin_locator: radial shell bin lookup for 3D points
// Computes the distance of a point from a configured centre and maps it
// through a coarse slot table and bin bounds tables to a shell bin.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) carries one opcode per transfer:
//    locate a point, write a coarse map slot, or write a bin entry.
//  - Output channel (out_valid / out_stall) returns exactly one result per
//    input transfer, in order; loads and the unused opcode answer zeros.
//  - Throughput is one transfer per cycle while no result waits on a stall.
//    From input transfer to output valid an item passes the difference,
//    square and sum stages, 32 square root stages, 32 divider stages for the
//    coarse slot, the coarse map and bin table reads, and the output register.
//  - Table writes happen at the same pipeline stage where the tables are
//    read, so a load is seen by every later locate.
//  - When the receiver stalls a valid result, the whole pipeline holds and
//    in_stall is raised; nothing is dropped.
//  - Reset clears all valid bits and sets the registers to their defaults.
//    Table contents are undefined until written; no clearing pass is run.
//  - Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module spherical_shell_bin_locator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [9:0]  table_index,
    input  logic [7:0]  map_bin,
    input  logic [31:0] bin_centre_in,
    input  logic [31:0] bin_width_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        in_bin,
    output logic [8:0]  bin_index,
    output logic [31:0] distance
);
    import ssbl_pkg::*;

    // Configuration registers
    logic signed [31:0] centre_x_reg, centre_y_reg, centre_z_reg;
    logic [31:0]        radius_reg, cw_reg;
    logic [10:0]        cc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            radius_reg   <= '0;
            cw_reg       <= 32'd65536;
            cc_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTRE_X:      centre_x_reg <= cfg_wdata;
                REG_CENTRE_Y:      centre_y_reg <= cfg_wdata;
                REG_CENTRE_Z:      centre_z_reg <= cfg_wdata;
                REG_SPHERE_RADIUS: radius_reg   <= cfg_wdata;
                REG_COARSE_WIDTH:  cw_reg       <= cfg_wdata;
                REG_COARSE_COUNT:  cc_reg       <= cfg_wdata[10:0];
                default:           ;
            endcase
        end
    end

    // Global advance: hold everything while a result waits on a stall
    logic adv;
    logic acc;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    // Stage 1: absolute coordinate differences
    function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        absdiff = d[32] ? 32'(-d) : d[31:0];
    endfunction

    logic        p1_vld_reg;
    side_t       p1_side_reg;
    logic [31:0] dx_reg, dy_reg, dz_reg;

    // Stage 2: squares
    logic        p2_vld_reg;
    side_t       p2_side_reg;
    logic [63:0] sx_reg, sy_reg, sz_reg;

    // Stage 3: sum of squares, saturated
    logic        p3_vld_reg;
    side_t       p3_side_reg;
    logic [63:0] ssum_reg;
    logic [65:0] ssum_next;

    assign ssum_next = {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= acc;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_side_reg <= '{op: opcode, idx: table_index, map_bin: map_bin,
                             bc: bin_centre_in, bw: bin_width_in};
            dx_reg      <= absdiff(pos_x, centre_x_reg);
            dy_reg      <= absdiff(pos_y, centre_y_reg);
            dz_reg      <= absdiff(pos_z, centre_z_reg);
            p2_side_reg <= p1_side_reg;
            sx_reg      <= dx_reg * dx_reg;
            sy_reg      <= dy_reg * dy_reg;
            sz_reg      <= dz_reg * dz_reg;
            p3_side_reg <= p2_side_reg;
            // saturate to all ones: its root is 0xFFFFFFFF
            ssum_reg    <= (|ssum_next[65:64]) ? '1 : ssum_next[63:0];
        end
    end

    // Square root pipeline
    logic        sq_vld;
    logic [31:0] sq_root;
    side_t       sq_side;

    ssbl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (p3_vld_reg),
        .in_val   (ssum_reg),
        .in_side  (p3_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // Divider pipeline: slot quotient r / coarse_width, one bit per stage
    logic        dv_vld_reg   [0:DIV_STAGES];
    side_t       dv_side_reg  [0:DIV_STAGES];
    logic [31:0] dv_r_reg     [0:DIV_STAGES];
    logic        dv_nobin_reg [0:DIV_STAGES];
    logic [31:0] dv_rem_reg   [0:DIV_STAGES];
    logic [31:0] dv_q_reg     [0:DIV_STAGES];

    always_comb
    begin
        dv_vld_reg[0]   = sq_vld;
        dv_side_reg[0]  = sq_side;
        dv_r_reg[0]     = sq_root;
        dv_nobin_reg[0] = (sq_root > radius_reg) || (cw_reg == '0);
        dv_rem_reg[0]   = '0;
        dv_q_reg[0]     = '0;
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            logic [32:0] trial;
            logic        ge;
            logic [32:0] diff;

            assign trial = {dv_rem_reg[k], dv_r_reg[k][DIV_STAGES-1-k]};
            assign ge    = trial >= {1'b0, cw_reg};
            assign diff  = trial - {1'b0, cw_reg};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vld_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_vld_reg[k+1] <= dv_vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_side_reg[k+1]  <= dv_side_reg[k];
                    dv_r_reg[k+1]     <= dv_r_reg[k];
                    dv_nobin_reg[k+1] <= dv_nobin_reg[k];
                    dv_rem_reg[k+1]   <= ge ? diff[31:0] : trial[31:0];
                    dv_q_reg[k+1]     <= {dv_q_reg[k][30:0], ge};
                end
            end
        end
    endgenerate

    // Coarse map stage: read the slot, or apply a map load
    side_t       d_side;
    logic [31:0] slot;
    logic [31:0] cnt;
    logic        d_hit;

    assign d_side = dv_side_reg[DIV_STAGES];

    always_comb
    begin
        slot  = (dv_q_reg[DIV_STAGES] == '0) ? '0 : dv_q_reg[DIV_STAGES] - 32'd1;
        cnt   = ({21'b0, cc_reg} > 32'(COARSE_SLOTS)) ? 32'(COARSE_SLOTS)
                                                      : {21'b0, cc_reg};
        d_hit = (d_side.op == OP_LOCATE) && !dv_nobin_reg[DIV_STAGES] && (slot < cnt);
    end

    logic [7:0] cm_rdata;

    ssbl_ram #(.WIDTH(8), .DEPTH(COARSE_SLOTS)) u_coarse_map (
        .clk   (clk),
        .we    (adv && dv_vld_reg[DIV_STAGES] && (d_side.op == OP_WR_MAP)
                && ({22'b0, d_side.idx} < 32'(COARSE_SLOTS))),
        .waddr (d_side.idx[CM_AW-1:0]),
        .wdata (d_side.map_bin),
        .re    (adv),
        .raddr (slot[CM_AW-1:0]),
        .rdata (cm_rdata)
    );

    logic        c_vld_reg;
    side_t       c_side_reg;
    logic [31:0] c_r_reg;
    logic        c_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= dv_vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= d_side;
            c_r_reg    <= dv_r_reg[DIV_STAGES];
            c_hit_reg  <= d_hit;
        end
    end

    // Bin table stage: read centre and width of the mapped bin, or load them
    logic        bin_we;
    logic [31:0] bc_rdata, bw_rdata;

    assign bin_we = adv && c_vld_reg && (c_side_reg.op == OP_WR_BIN)
                    && ({22'b0, c_side_reg.idx} < 32'(MAX_BINS));

    ssbl_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_bin_centres (
        .clk   (clk),
        .we    (bin_we),
        .waddr (c_side_reg.idx[BIN_AW-1:0]),
        .wdata (c_side_reg.bc),
        .re    (adv),
        .raddr (cm_rdata[BIN_AW-1:0]),
        .rdata (bc_rdata)
    );

    ssbl_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_bin_widths (
        .clk   (clk),
        .we    (bin_we),
        .waddr (c_side_reg.idx[BIN_AW-1:0]),
        .wdata (c_side_reg.bw),
        .re    (adv),
        .raddr (cm_rdata[BIN_AW-1:0]),
        .rdata (bw_rdata)
    );

    logic        b_vld_reg;
    logic [1:0]  b_op_reg;
    logic [31:0] b_r_reg;
    logic        b_hit_reg;
    logic [7:0]  b_n_reg;
    logic        b_nok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_op_reg  <= c_side_reg.op;
            b_r_reg   <= c_r_reg;
            b_hit_reg <= c_hit_reg;
            b_n_reg   <= cm_rdata;
            b_nok_reg <= {24'b0, cm_rdata} < 32'(MAX_BINS);
        end
    end

    // Bounds check on doubled values: 2r + w >= 2c and 2r < 2c + w
    logic [33:0] c2, w2, r2;
    logic        in_bounds;

    always_comb
    begin
        c2        = b_nok_reg ? {1'b0, bc_rdata, 1'b0} : '0;
        w2        = b_nok_reg ? {2'b00, bw_rdata} : '0;
        r2        = {1'b0, b_r_reg, 1'b0};
        in_bounds = ((r2 + w2) >= c2) && (r2 < (c2 + w2));
    end

    // Output register
    logic        in_bin_reg;
    logic [8:0]  bin_index_reg;
    logic [31:0] distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_bin_reg    <= b_hit_reg;
            // a miss on the mapped bin steps to the next bin, unchecked
            bin_index_reg <= b_hit_reg ? ({1'b0, b_n_reg} + {8'b0, !in_bounds}) : '0;
            distance_reg  <= (b_op_reg == OP_LOCATE) ? b_r_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_bin    = in_bin_reg;
    assign bin_index = bin_index_reg;
    assign distance  = distance_reg;

`ifndef SYNTHESIS
    a_nobin_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_bin |-> bin_index == '0)
        else $error("bin_index nonzero without a bin");

    a_bin_within_radius: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_bin |-> distance <= radius_reg)
        else $error("bin found beyond sphere radius");

    a_bin_needs_slots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_bin |-> cc_reg != '0 && cw_reg != '0)
        else $error("bin found with no coarse slots");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance))
        else $error("result changed under stall");
`endif

endmodule

// ===== rtl/ssbl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbl_ram: generic simple dual port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module ssbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ssbl_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbl_sqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage, with the
// item sideband carried alongside.
// ----------------------------------------------------------------------------
module ssbl_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [63:0]    in_val,
    input  ssbl_pkg::side_t in_side,
    output logic           out_vld,
    output logic [31:0]    out_root,
    output ssbl_pkg::side_t out_side
);
    import ssbl_pkg::*;

    logic        vld_reg  [0:SQRT_STAGES];
    logic [63:0] v_reg    [0:SQRT_STAGES];
    logic [63:0] res_reg  [0:SQRT_STAGES];
    side_t       side_reg [0:SQRT_STAGES];

    always_comb
    begin
        vld_reg[0]  = in_vld;
        v_reg[0]    = in_val;
        res_reg[0]  = '0;
        side_reg[0] = in_side;
    end

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] trial;
            logic [63:0] v_next;
            logic [63:0] res_next;

            always_comb
            begin
                trial = res_reg[k] + BIT;
                if (v_reg[k] >= trial)
                begin
                    v_next   = v_reg[k] - trial;
                    res_next = (res_reg[k] >> 1) + BIT;
                end
                else
                begin
                    v_next   = v_reg[k];
                    res_next = res_reg[k] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k+1]    <= v_next;
                    res_reg[k+1]  <= res_next;
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[SQRT_STAGES];
    assign out_root = res_reg[SQRT_STAGES][31:0];
    assign out_side = side_reg[SQRT_STAGES];

endmodule
